// ===== hdl/ordered_key_list_assert.svh =====
// Assertion macros used by the checker file of the ordered key list.
`ifndef ORDERED_KEY_LIST_ASSERT_SVH
`define ORDERED_KEY_LIST_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define OKL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define OKL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define OKL_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/okl_pkg.sv =====
`default_nettype none

package okl_pkg;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_BYTES_DEF = 8;

    // Fixed port widths.
    localparam int ACT_W = 2;
    localparam int KEY_W = 64;
    localparam int POS_W = 4;
    localparam int CNT_W = 5;

    typedef enum logic [ACT_W-1:0] {
        OKL_APPEND = 2'd0,
        OKL_REMOVE = 2'd1,
        OKL_READ   = 2'd2,
        OKL_CLEAR  = 2'd3
    } t_okl_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_DONE
    } t_okl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic shift;
        logic load_out;
    } t_okl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_remove;
    } t_okl_stat;

endpackage

`default_nettype wire

// ===== hdl/okl_ctrl.sv =====
`default_nettype none

module okl_ctrl (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_valid,
    output logic                     o_ready,
    output logic                     o_valid,
    input  wire                logic i_ready,
    input  wire okl_pkg::t_okl_stat  i_stat,
    output okl_pkg::t_okl_cmd        o_cmd
);

    okl_pkg::t_okl_state r_state;
    okl_pkg::t_okl_state n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= okl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            okl_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = okl_pkg::ST_EXEC;
                end
            end
            okl_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.is_remove) begin
                    n_state = okl_pkg::ST_SHIFT;
                end else begin
                    n_state = okl_pkg::ST_DONE;
                end
            end
            okl_pkg::ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = okl_pkg::ST_DONE;
            end
            okl_pkg::ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_ready        = 1'b1;
                    if (i_valid) begin
                        o_cmd.load_item = 1'b1;
                        n_state         = okl_pkg::ST_EXEC;
                    end else begin
                        n_state = okl_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = okl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/okl_dpath.sv =====
`default_nettype none

module okl_dpath #(
    parameter int CAPACITY  = okl_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES = okl_pkg::KEY_BYTES_DEF
) (
    input  wire                logic                     i_clk,
    input  wire                logic                     i_rst_n,
    input  wire okl_pkg::t_okl_cmd                       i_cmd,
    output okl_pkg::t_okl_stat                           o_stat,
    input  wire                logic [okl_pkg::ACT_W-1:0] i_action,
    input  wire                logic [okl_pkg::KEY_W-1:0] i_key,
    input  wire                logic [okl_pkg::POS_W-1:0] i_position,
    output logic                                         o_ok,
    output logic [okl_pkg::KEY_W-1:0]                    o_read_key,
    output logic [okl_pkg::CNT_W-1:0]                    o_count,
    output logic                                         o_is_empty,
    output logic                                         o_is_full
);

    localparam int SKW  = KEY_BYTES * 8;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > okl_pkg::POS_W) ? CW : okl_pkg::POS_W;

    okl_pkg::t_okl_action      r_action;
    logic [SKW-1:0]            r_key;
    logic [okl_pkg::POS_W-1:0] r_pos;
    logic [SKW-1:0]            r_entries [CAPACITY];
    logic [CW-1:0]             r_used;
    logic [CW-1:0]             n_used;
    logic [CAPACITY-1:0]       r_match;
    logic                      r_ok;
    logic                      n_ok;
    logic [SKW-1:0]            r_rd;
    logic [SKW-1:0]            n_rd;
    logic [CAPACITY-1:0]       aft;
    logic [CMPW-1:0]           pos_x;
    logic [IW-1:0]             rd_idx;
    logic                      rd_ok;
    logic                      hit;

    assign o_stat.is_remove = (r_action == okl_pkg::OKL_REMOVE);

    assign pos_x  = CMPW'(r_pos);
    assign rd_idx = pos_x[IW-1:0];
    assign rd_ok  = (pos_x < CMPW'(r_used)) && (pos_x < CMPW'(CAPACITY));
    assign hit    = |r_match;

    // Entries at or above the first match move down one place.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            aft[i] = 1'b0;
            for (int j = 0; j < CAPACITY; j++) begin
                if (j <= i) begin
                    aft[i] = aft[i] | r_match[j];
                end
            end
        end
    end

    always_comb begin
        n_used = r_used;
        n_ok   = r_ok;
        n_rd   = r_rd;
        if (i_cmd.exec) begin
            n_ok = 1'b0;
            n_rd = '0;
            case (r_action)
                okl_pkg::OKL_APPEND: begin
                    if (r_used < CW'(CAPACITY)) begin
                        n_used = r_used + CW'(1);
                        n_ok   = 1'b1;
                    end
                end
                okl_pkg::OKL_READ: begin
                    if (rd_ok) begin
                        n_rd = r_entries[rd_idx];
                        n_ok = 1'b1;
                    end
                end
                okl_pkg::OKL_CLEAR: begin
                    n_used = '0;
                    n_ok   = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.shift) begin
            n_ok = hit;
            n_rd = '0;
            if (hit) begin
                n_used = r_used - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok <= n_ok;
        r_rd <= n_rd;
        if (i_cmd.load_item) begin
            r_action <= okl_pkg::t_okl_action'(i_action);
            r_key    <= i_key[SKW-1:0];
            r_pos    <= i_position;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_match[i] <= (CW'(i) < r_used) && (r_entries[i] == r_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_action == okl_pkg::OKL_APPEND) && (r_used < CW'(CAPACITY))) begin
            r_entries[r_used[IW-1:0]] <= r_key;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (aft[i]) begin
                    r_entries[i] <= r_entries[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_ok       <= r_ok;
            o_read_key <= okl_pkg::KEY_W'(r_rd);
            o_count    <= okl_pkg::CNT_W'(r_used);
            o_is_empty <= (r_used == '0);
            o_is_full  <= (r_used == CW'(CAPACITY));
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ordered_key_list.sv =====
// Ordered key list: a list of up to CAPACITY keys of KEY_BYTES bytes each, held in the
// order they were appended. Each request carries an action: append puts the key at the
// end (refused when the list is full), remove deletes the lowest-placed entry equal to the
// key and closes the gap (refused when the list is empty or the key is absent), read
// returns the key at a position (refused at or beyond the count), and clear empties the
// list. Only the low KEY_BYTES bytes of a key are stored and compared. Every request gives
// exactly one result carrying the success flag, the read data (zero unless a read
// succeeded), and the count, empty and full status after the action. A request is taken
// in the idle state, or at the same clock edge at which the previous result is staged:
// append, read and clear pass through the execute state and then the hand-over state,
// in which the result is staged; remove adds a shift state between the two, in which
// the match vector from the parallel compare closes the gap by shifting the upper
// entries down. The next request is taken only once the previous one is handed over.
// The result sits in an output register, so a new request is taken while the previous
// result still waits for the consumer. The entries need no clearing after reset, as only
// positions below the count are ever read.
`default_nettype none

module ordered_key_list #(
    parameter int CAPACITY  = okl_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES = okl_pkg::KEY_BYTES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [okl_pkg::ACT_W-1:0] i_action,
    input  wire logic [okl_pkg::KEY_W-1:0] i_key,
    input  wire logic [okl_pkg::POS_W-1:0] i_position,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic                           o_ok,
    output logic [okl_pkg::KEY_W-1:0]      o_read_key,
    output logic [okl_pkg::CNT_W-1:0]      o_count,
    output logic                           o_is_empty,
    output logic                           o_is_full
);

    // Command and status bundles between the sequencer and the list storage.
    okl_pkg::t_okl_cmd  cmd;
    okl_pkg::t_okl_stat stat;

    // The sequencer owns the handshakes and decides when the storage executes,
    // shifts and hands its result to the output register.
    okl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The storage holds the entries, the count, the match vector and the result.
    okl_dpath #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_action   (i_action),
        .i_key      (i_key),
        .i_position (i_position),
        .o_ok       (o_ok),
        .o_read_key (o_read_key),
        .o_count    (o_count),
        .o_is_empty (o_is_empty),
        .o_is_full  (o_is_full)
    );

endmodule

`default_nettype wire

// ===== hdl/okl_checker.sv =====
`default_nettype none
`include "ordered_key_list_assert.svh"

module okl_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire logic [okl_pkg::ACT_W-1:0] i_action,
    input wire logic [okl_pkg::KEY_W-1:0] i_key,
    input wire logic [okl_pkg::POS_W-1:0] i_position,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic                      o_ok,
    input wire logic [okl_pkg::KEY_W-1:0] o_read_key,
    input wire logic [okl_pkg::CNT_W-1:0] o_count,
    input wire logic                      o_is_empty,
    input wire logic                      o_is_full
);

    logic in_seen;

    assign in_seen = i_valid && o_ready && (i_action != '0 || i_key != '0 || i_position != '0);

    `OKL_ASSERT_RST(a_rst_no_result, !i_rst_n, !o_valid, "result shown straight after reset")
    `OKL_ASSERT_NOW(a_empty_count, o_valid, o_is_empty == (o_count == '0), "empty flag disagrees with count")
    `OKL_ASSERT_NOW(a_empty_full, o_valid, !(o_is_empty && o_is_full), "list both empty and full")
    `OKL_ASSERT_NOW(a_fail_no_data, o_valid && !o_ok, o_read_key == '0, "failed request returns data")
    `OKL_ASSERT_NEXT(a_stall_hold, o_valid && !i_ready && !in_seen, o_valid && $stable(o_read_key), "stalled result changed")

endmodule

bind ordered_key_list okl_checker u_okl_checker (.*);

`default_nettype wire
